FILE: design/sddd_pkg.sv
// Package: types, constants and helper functions for the date difference core.
`timescale 1ns / 1ps

package sddd_pkg;

  localparam int unsigned DAY_W   = 5;
  localparam int unsigned MONTH_W = 4;
  localparam int unsigned YEAR_W  = 14;
  localparam int unsigned DIFF_W  = 23;
  localparam int unsigned NUM_W   = 23;
  localparam int unsigned Q100_W  = 8;
  localparam int unsigned OFF_W   = 9;
  localparam int unsigned PROD_W  = 27;

  localparam logic [YEAR_W-1:0]  YEAR_MIN    = 14'd1;
  localparam logic [YEAR_W-1:0]  YEAR_MAX    = 14'd9999;
  localparam logic [12:0]        RECIP_100   = 13'd5243;
  localparam int unsigned        RECIP_SHIFT = 19;
  localparam logic [MONTH_W-1:0] MONTH_JAN   = 4'd1;
  localparam logic [MONTH_W-1:0] MONTH_FEB   = 4'd2;
  localparam logic [MONTH_W-1:0] MONTH_DEC   = 4'd12;
  localparam logic [DAY_W-1:0]   FEB_LEAP    = 5'd29;

  typedef struct packed {
    logic               basic_ok;
    logic               is_feb;
    logic [DAY_W-1:0]   day;
    logic [DAY_W-1:0]   len_base;
    logic [YEAR_W-1:0]  year;
    logic [YEAR_W-1:0]  yy;
    logic [Q100_W-1:0]  q100_y;
    logic [Q100_W-1:0]  q100_yy;
    logic [NUM_W-1:0]   mul365;
    logic [OFF_W-1:0]   offset;
  } date_a_t;

  typedef struct packed {
    logic             ok;
    logic [NUM_W-1:0] num;
  } date_b_t;

  function automatic logic [DAY_W-1:0] month_len(input logic [MONTH_W-1:0] m);
    logic [DAY_W-1:0] len;
    case (m)
      4'd1:    len = 5'd31;
      4'd2:    len = 5'd28;
      4'd3:    len = 5'd31;
      4'd4:    len = 5'd30;
      4'd5:    len = 5'd31;
      4'd6:    len = 5'd30;
      4'd7:    len = 5'd31;
      4'd8:    len = 5'd31;
      4'd9:    len = 5'd30;
      4'd10:   len = 5'd31;
      4'd11:   len = 5'd30;
      4'd12:   len = 5'd31;
      default: len = 5'd0;
    endcase
    return len;
  endfunction

  // Days before the month in a year that starts in March.
  function automatic logic [OFF_W-1:0] month_offset(input logic [MONTH_W-1:0] m);
    logic [OFF_W-1:0] off;
    case (m)
      4'd3:    off = 9'd0;
      4'd4:    off = 9'd31;
      4'd5:    off = 9'd61;
      4'd6:    off = 9'd92;
      4'd7:    off = 9'd122;
      4'd8:    off = 9'd153;
      4'd9:    off = 9'd184;
      4'd10:   off = 9'd214;
      4'd11:   off = 9'd245;
      4'd12:   off = 9'd275;
      4'd1:    off = 9'd306;
      4'd2:    off = 9'd337;
      default: off = 9'd0;
    endcase
    return off;
  endfunction

  function automatic logic [Q100_W-1:0] div100(input logic [YEAR_W-1:0] v);
    logic [PROD_W-1:0] p;
    p = {13'b0, v} * {14'b0, RECIP_100};
    return p[PROD_W-1:RECIP_SHIFT];
  endfunction

  function automatic date_a_t date_a(input logic [DAY_W-1:0] d,
                                     input logic [MONTH_W-1:0] m,
                                     input logic [YEAR_W-1:0] y);
    date_a_t a;
    a.basic_ok = (m >= MONTH_JAN) && (m <= MONTH_DEC) && (y >= YEAR_MIN) &&
                 (y <= YEAR_MAX) && (d != '0);
    a.is_feb   = (m == MONTH_FEB);
    a.day      = d;
    a.len_base = month_len(m);
    a.year     = y;
    a.yy       = (m <= MONTH_FEB) ? y - YEAR_MIN : y;
    a.q100_y   = div100(y);
    a.q100_yy  = div100(a.yy);
    a.mul365   = {9'b0, a.yy} * 23'd365;
    a.offset   = month_offset(m);
    return a;
  endfunction

  function automatic date_b_t date_b(input date_a_t a);
    date_b_t          b;
    logic [YEAR_W-1:0] h;
    logic             rem0;
    logic             leap;
    logic [DAY_W-1:0] len;
    h    = {6'b0, a.q100_y} * 14'd100;
    rem0 = (h == a.year);
    leap = ((a.year[1:0] == 2'b00) && !rem0) || (rem0 && (a.q100_y[1:0] == 2'b00));
    len  = (a.is_feb && leap) ? FEB_LEAP : a.len_base;
    b.ok = a.basic_ok && (a.day <= len);
    b.num = a.mul365 + {11'b0, a.yy[YEAR_W-1:2]} - {15'b0, a.q100_yy}
          + {17'b0, a.q100_yy[Q100_W-1:2]} + {14'b0, a.offset} + {18'b0, a.day};
    return b;
  endfunction

endpackage

FILE: design/signed_date_difference_days_core.sv
// Top level: pipelined signed day count between two Gregorian dates.
//
//   channel  direction  handshake                 payload
//   in       request    in_valid_i / in_stall_o   first_*, second_*, include_end_i
//   out      result     out_valid_o / out_stall_i day_difference_o, invalid_date_o
//
// Four register stages: reciprocal divides and 365x multiply, day numbers
// and validity, difference, end-day adjust into the output register.
// One request per cycle while out_stall_i is low; a result moves through the a, b and c stages to the output.
// Reset clears the valid bits of all stages; payload registers are not reset.
// Each stage advances when it is empty or the stage after it advances.
`timescale 1ns / 1ps

module signed_date_difference_days_core (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  logic [sddd_pkg::DAY_W-1:0]    first_day_i,
  input  logic [sddd_pkg::MONTH_W-1:0]  first_month_i,
  input  logic [sddd_pkg::YEAR_W-1:0]   first_year_i,
  input  logic [sddd_pkg::DAY_W-1:0]    second_day_i,
  input  logic [sddd_pkg::MONTH_W-1:0]  second_month_i,
  input  logic [sddd_pkg::YEAR_W-1:0]   second_year_i,
  input  logic                          include_end_i,
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output logic [sddd_pkg::DIFF_W-1:0]   day_difference_o,
  output logic                          invalid_date_o
);

  logic a_valid_q, b_valid_q, c_valid_q, out_valid_q;
  logic en_a, en_b, en_c, en_d;

  sddd_pkg::date_a_t a1_d, a2_d, a1_q, a2_q;
  logic              a_incl_q;
  sddd_pkg::date_b_t b1_d, b2_d, b1_q, b2_q;
  logic              b_incl_q;

  logic signed [sddd_pkg::DIFF_W:0] diff_d, diff_q;
  logic                             c_invalid_d, c_invalid_q, c_incl_q;

  logic signed [sddd_pkg::DIFF_W:0] adj_d;
  logic [sddd_pkg::DIFF_W-1:0]      day_difference_d, day_difference_q;
  logic                             invalid_date_q;

  assign en_d = !out_valid_q || !out_stall_i;
  assign en_c = !c_valid_q || en_d;
  assign en_b = !b_valid_q || en_c;
  assign en_a = !a_valid_q || en_b;
  assign in_stall_o = !en_a;

  always_comb begin
    a1_d = sddd_pkg::date_a(first_day_i, first_month_i, first_year_i);
    a2_d = sddd_pkg::date_a(second_day_i, second_month_i, second_year_i);
    b1_d = sddd_pkg::date_b(a1_q);
    b2_d = sddd_pkg::date_b(a2_q);
    diff_d = $signed({1'b0, b2_q.num}) - $signed({1'b0, b1_q.num});
    c_invalid_d = !(b1_q.ok && b2_q.ok);
  end

  always_comb begin
    if (!c_incl_q) begin
      adj_d = diff_q;
    end else if (diff_q > 0) begin
      adj_d = diff_q + 24'sd1;
    end else begin
      adj_d = diff_q - 24'sd1;
    end
    day_difference_d = c_invalid_q ? '0 : adj_d[sddd_pkg::DIFF_W-1:0];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_valid_q   <= 1'b0;
      b_valid_q   <= 1'b0;
      c_valid_q   <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (en_a) a_valid_q <= in_valid_i;
      if (en_b) b_valid_q <= a_valid_q;
      if (en_c) c_valid_q <= b_valid_q;
      if (en_d) out_valid_q <= c_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_a && in_valid_i) begin
      a1_q     <= a1_d;
      a2_q     <= a2_d;
      a_incl_q <= include_end_i;
    end
    if (en_b && a_valid_q) begin
      b1_q     <= b1_d;
      b2_q     <= b2_d;
      b_incl_q <= a_incl_q;
    end
    if (en_c && b_valid_q) begin
      diff_q      <= diff_d;
      c_invalid_q <= c_invalid_d;
      c_incl_q    <= b_incl_q;
    end
    if (en_d && c_valid_q) begin
      day_difference_q <= day_difference_d;
      invalid_date_q   <= c_invalid_q;
    end
  end

  assign out_valid_o      = out_valid_q;
  assign day_difference_o = day_difference_q;
  assign invalid_date_o   = invalid_date_q;

`ifndef SYNTHESIS
  a_invalid_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && invalid_date_o |-> day_difference_o == '0)
    else $error("invalid result with nonzero difference");

  a_accept_fills: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o |=> a_valid_q)
    else $error("accepted request lost at first stage");

  a_incl_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    c_valid_q && en_d && c_incl_q && !c_invalid_q |=> day_difference_o != '0)
    else $error("end-day count gave zero difference");
`endif

endmodule
